@@ sv/wbpe_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wbpe_pkg: shared types and constants of the window bitmap pixel expander
// Command bytes, field widths, register indexes and the queue item types.
// ---------------------------------------------------------------------------
package wbpe_pkg;

	localparam int COORD_W = 9;
	localparam int WORD_W  = 16;
	localparam int LEFT_W  = 17;
	localparam int unsigned LEFT_MAX = 32'h0001_ffff;

	localparam int BITS_PER_WORD_DEF = 32;
	localparam int MAX_SIDE_DEF      = 320;
	localparam int QUEUE_DEPTH_DEF   = 4;

	localparam logic [7:0] CMD_COL_SET   = 8'h2a;
	localparam logic [7:0] CMD_PAGE_SET  = 8'h2b;
	localparam logic [7:0] CMD_MEM_WRITE = 8'h2c;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

	typedef enum logic {
		OP_WINDOW = 1'b0,
		OP_PIXELS = 1'b1
	} op_kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [WORD_W-1:0]  x_end;
		logic [WORD_W-1:0]  y_end;
	} win_op_t;

	typedef struct packed {
		logic              is_data;
		logic              is_word;
		logic [WORD_W-1:0] value;
		logic              last;
		logic              window_done;
	} result_t;

endpackage

`default_nettype wire

@@ sv/wbpe_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wbpe_queue: short first-in first-out queue
// Holds classified items between the front and the back part.
// ---------------------------------------------------------------------------
module wbpe_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNTW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNTW'(1);
				2'b01: count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/wbpe_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wbpe_front: item intake and classification
// Keeps the window pixel count, sizes each bitmap word and queues the work.
// ---------------------------------------------------------------------------
module wbpe_front
	import wbpe_pkg::*;
#(
	parameter int BITS_PER_WORD = BITS_PER_WORD_DEF,
	parameter int MAX_SIDE      = MAX_SIDE_DEF,
	localparam int CW = $clog2(BITS_PER_WORD + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     cmd,
	input  wire logic [COORD_W-1:0]       win_x,
	input  wire logic [COORD_W-1:0]       win_y,
	input  wire logic [COORD_W-1:0]       win_width,
	input  wire logic [COORD_W-1:0]       win_height,
	input  wire logic [BITS_PER_WORD-1:0] bits,
	input  wire logic                     q_full,
	output logic                          q_push,
	output op_kind_t                      op_kind,
	output win_op_t                       op_win,
	output logic [BITS_PER_WORD-1:0]      op_word,
	output logic [CW-1:0]                 op_count,
	output logic                          op_done
);

	localparam longint unsigned CAP_RAW = longint'(MAX_SIDE) * longint'(MAX_SIDE);
	localparam logic [LEFT_W-1:0] CAP =
		(CAP_RAW > longint'(LEFT_MAX)) ? LEFT_W'(LEFT_MAX) : LEFT_W'(CAP_RAW);

	logic [LEFT_W-1:0]    pixels_left_q;
	logic [2*COORD_W-1:0] area;
	logic [LEFT_W-1:0]    area_sat;
	logic                 take;
	logic                 fits;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	assign area     = (2*COORD_W)'(win_width) * (2*COORD_W)'(win_height);
	assign area_sat = (area > {1'b0, CAP}) ? CAP : area[LEFT_W-1:0];

	// A word carries the rest of the window when the count fits in it.
	assign fits     = (pixels_left_q <= LEFT_W'(BITS_PER_WORD));
	assign op_count = fits ? pixels_left_q[CW-1:0] : CW'(BITS_PER_WORD);
	assign op_done  = fits;

	assign op_kind       = op_kind_t'(cmd);
	assign op_word       = bits;
	assign op_win.x      = win_x;
	assign op_win.y      = win_y;
	assign op_win.x_end  = WORD_W'(win_x) + WORD_W'(win_width) - WORD_W'(1);
	assign op_win.y_end  = WORD_W'(win_y) + WORD_W'(win_height) - WORD_W'(1);

	// A word that arrives with no pixels left is taken and dropped.
	assign q_push = take && (op_kind == OP_WINDOW || pixels_left_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
		end else if (take) begin
			if (op_kind == OP_WINDOW) begin
				pixels_left_q <= area_sat;
			end else begin
				pixels_left_q <= pixels_left_q - LEFT_W'(op_count);
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/wbpe_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wbpe_back: result sequencer
// Expands queued window and bitmap work, one result per cycle unless stalled.
// ---------------------------------------------------------------------------
module wbpe_back
	import wbpe_pkg::*;
#(
	parameter int BITS_PER_WORD = BITS_PER_WORD_DEF,
	localparam int CW = $clog2(BITS_PER_WORD + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     q_empty,
	output logic                          q_pop,
	input  wire op_kind_t                 q_kind,
	input  wire win_op_t                  q_win,
	input  wire logic [BITS_PER_WORD-1:0] q_word,
	input  wire logic [CW-1:0]            q_count,
	input  wire logic                     q_done,
	input  wire logic [WORD_W-1:0]        fg_color,
	input  wire logic [WORD_W-1:0]        bg_color,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output result_t                       result
);

	// Window results are counted down from seven to one.
	localparam logic [2:0] WSTEP_COL_CMD  = 3'd7;
	localparam logic [2:0] WSTEP_X        = 3'd6;
	localparam logic [2:0] WSTEP_X_END    = 3'd5;
	localparam logic [2:0] WSTEP_PAGE_CMD = 3'd4;
	localparam logic [2:0] WSTEP_Y        = 3'd3;
	localparam logic [2:0] WSTEP_Y_END    = 3'd2;
	localparam logic [2:0] WSTEP_MEM_CMD  = 3'd1;

	logic                     busy_q;
	op_kind_t                 kind_q;
	win_op_t                  win_q;
	logic [BITS_PER_WORD-1:0] word_q;
	logic [CW-1:0]            rem_q;
	logic                     done_q;
	logic                     out_valid_q;
	result_t                  res_q;
	result_t                  res;
	logic                     adv;
	logic                     last;

	assign adv   = !out_valid_q || !out_stall;
	assign last  = (rem_q == CW'(1));
	assign q_pop = !q_empty && (!busy_q || (adv && last));

	always_comb begin
		res = '0;
		res.last = last;
		unique case (kind_q)
			OP_WINDOW: begin
				unique case (rem_q[2:0])
					WSTEP_COL_CMD:  res.value = WORD_W'(CMD_COL_SET);
					WSTEP_X:        res.value = WORD_W'(win_q.x);
					WSTEP_X_END:    res.value = win_q.x_end;
					WSTEP_PAGE_CMD: res.value = WORD_W'(CMD_PAGE_SET);
					WSTEP_Y:        res.value = WORD_W'(win_q.y);
					WSTEP_Y_END:    res.value = win_q.y_end;
					WSTEP_MEM_CMD:  res.value = WORD_W'(CMD_MEM_WRITE);
					default:        res.value = '0;
				endcase
				res.is_data = !(rem_q[2:0] == WSTEP_COL_CMD || rem_q[2:0] == WSTEP_PAGE_CMD
					|| rem_q[2:0] == WSTEP_MEM_CMD);
				res.is_word = res.is_data;
			end
			OP_PIXELS: begin
				res.is_data     = 1'b1;
				res.is_word     = 1'b1;
				res.value       = word_q[BITS_PER_WORD-1] ? fg_color : bg_color;
				res.window_done = last && done_q;
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			res_q <= res;
		end
		if (q_pop) begin
			kind_q <= q_kind;
			win_q  <= q_win;
			word_q <= q_word;
			done_q <= q_done;
		end else if (adv && busy_q) begin
			word_q <= word_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				rem_q  <= (q_kind == OP_WINDOW) ? CW'(WSTEP_COL_CMD) : q_count;
			end else if (adv && busy_q) begin
				rem_q <= rem_q - CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

`default_nettype wire

@@ sv/window_bitmap_pixel_expander.sv @@
`default_nettype none
// Accepted items pass the queue, then the sequencer, then the result register.
// The result sequencer sends one result per cycle unless out_stall is high, and
// starts the next item without a gap; a window gives 7 results and a bitmap word
// one per pixel (32 for a full 32-bit word); a word with no pixels left, none.
// Reset: the pixel count and the queue are empty, fg_color is 0xffff, bg_color is 0.
// ---------------------------------------------------------------------------
// window_bitmap_pixel_expander: drawing requests to a display write stream
// Window items become address commands, bitmap words become pixel colors.
// ---------------------------------------------------------------------------
module window_bitmap_pixel_expander
	import wbpe_pkg::*;
#(
	parameter int BITS_PER_WORD = BITS_PER_WORD_DEF,
	parameter int MAX_SIDE      = MAX_SIDE_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [WORD_W-1:0]        cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     cmd,
	input  wire logic [COORD_W-1:0]       win_x,
	input  wire logic [COORD_W-1:0]       win_y,
	input  wire logic [COORD_W-1:0]       win_width,
	input  wire logic [COORD_W-1:0]       win_height,
	input  wire logic [BITS_PER_WORD-1:0] bits,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          is_data,
	output logic                          is_word,
	output logic [WORD_W-1:0]             value,
	output logic                          last,
	output logic                          window_done
);

	localparam int CW = $clog2(BITS_PER_WORD + 1);
	localparam int QW = 1 + $bits(win_op_t) + BITS_PER_WORD + CW + 1;

	logic [WORD_W-1:0] fg_q;
	logic [WORD_W-1:0] bg_q;

	logic                     q_full;
	logic                     q_empty;
	logic                     q_push;
	logic                     q_pop;
	logic [QW-1:0]            q_din;
	logic [QW-1:0]            q_dout;

	op_kind_t                 f_kind;
	win_op_t                  f_win;
	logic [BITS_PER_WORD-1:0] f_word;
	logic [CW-1:0]            f_count;
	logic                     f_done;

	logic                     b_kind_bit;
	win_op_t                  b_win;
	logic [BITS_PER_WORD-1:0] b_word;
	logic [CW-1:0]            b_count;
	logic                     b_done;
	result_t                  result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= '1;
			bg_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FG_COLOR: fg_q <= cfg_data;
				REG_BG_COLOR: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wbpe_front #(
		.BITS_PER_WORD(BITS_PER_WORD),
		.MAX_SIDE(MAX_SIDE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.win_x(win_x),
		.win_y(win_y),
		.win_width(win_width),
		.win_height(win_height),
		.bits(bits),
		.q_full(q_full),
		.q_push(q_push),
		.op_kind(f_kind),
		.op_win(f_win),
		.op_word(f_word),
		.op_count(f_count),
		.op_done(f_done)
	);

	assign q_din = {f_kind, f_win, f_word, f_count, f_done};

	wbpe_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(q_din),
		.full(q_full),
		.pop(q_pop),
		.dout(q_dout),
		.empty(q_empty)
	);

	assign {b_kind_bit, b_win, b_word, b_count, b_done} = q_dout;

	wbpe_back #(
		.BITS_PER_WORD(BITS_PER_WORD)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_kind(op_kind_t'(b_kind_bit)),
		.q_win(b_win),
		.q_word(b_word),
		.q_count(b_count),
		.q_done(b_done),
		.fg_color(fg_q),
		.bg_color(bg_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result)
	);

	assign is_data     = result.is_data;
	assign is_word     = result.is_word;
	assign value       = result.value;
	assign last        = result.last;
	assign window_done = result.window_done;

endmodule

`default_nettype wire

@@ sv/wbpe_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// wbpe_checker: port-level checks of the window bitmap pixel expander
// Watches the result stream for properties of the command and pixel words.
// ---------------------------------------------------------------------------
module wbpe_checker
	import wbpe_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic                     is_data,
	input wire logic                     is_word,
	input wire logic [WORD_W-1:0]        value,
	input wire logic                     last,
	input wire logic                     window_done
);

	// A stalled item stays on the port unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(last))
		else $error("result changed while stalled");

	// The pixel that empties a window closes its word.
	a_done_is_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_done |-> last && is_data && is_word)
		else $error("window_done outside the last pixel of a word");

	// Command bytes are narrow and never mark the end of a window.
	a_cmd_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data |-> !is_word && value[15:8] == 8'h00 && !window_done)
		else $error("malformed command byte");

	// A window ends with the memory-write command.
	a_window_ends_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data && last |-> value == WORD_W'(CMD_MEM_WRITE))
		else $error("window sequence ends with the wrong command");

endmodule

bind window_bitmap_pixel_expander wbpe_checker u_wbpe_checker (.*);

`default_nettype wire

@@ sim/window_bitmap_pixel_expander_tb.sv @@
// ---------------------------------------------------------------------------
// window_bitmap_pixel_expander_tb: self-checking bench of the pixel expander
// Drives window and bitmap items with bursty timing against a stalling sink,
// predicts the command and pixel stream, and checks every result in order.
// ---------------------------------------------------------------------------
import wbpe_pkg::*;

typedef struct {
	op_kind_t            kind;
	logic [COORD_W-1:0]  x;
	logic [COORD_W-1:0]  y;
	logic [COORD_W-1:0]  w;
	logic [COORD_W-1:0]  h;
	logic [31:0]         bits;
} draw_req_t;

class expander_scoreboard;
	logic [WORD_W-1:0] fg_color;
	logic [WORD_W-1:0] bg_color;
	int unsigned       pixels_left;
	result_t           stream_q[$];
	int                errors;

	function new();
		errors = 0;
		clear();
	endfunction

	function void clear();
		fg_color = 16'hffff;
		bg_color = 16'h0000;
		pixels_left = 0;
		stream_q.delete();
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
		case (idx)
			REG_FG_COLOR: fg_color = data;
			REG_BG_COLOR: bg_color = data;
			default: ;
		endcase
	endfunction

	function void push(logic is_data, logic is_word, logic [WORD_W-1:0] value,
			logic last, logic done);
		result_t r;
		r.is_data = is_data;
		r.is_word = is_word;
		r.value = value;
		r.last = last;
		r.window_done = done;
		stream_q.push_back(r);
	endfunction

	// Returns the number of results the item is expected to cause.
	function int note_request(draw_req_t req);
		logic [WORD_W-1:0] x_end;
		logic [WORD_W-1:0] y_end;
		int unsigned area;
		int unsigned area_cap;
		int unsigned n;
		logic last;
		if (req.kind == OP_WINDOW) begin
			x_end = {7'd0, req.x} + {7'd0, req.w} - 16'd1;
			y_end = {7'd0, req.y} + {7'd0, req.h} - 16'd1;
			area = int'(req.w) * int'(req.h);
			area_cap = MAX_SIDE_DEF * MAX_SIDE_DEF;
			if (area_cap > LEFT_MAX)
				area_cap = LEFT_MAX;
			if (area > area_cap)
				area = area_cap;
			pixels_left = area;
			push(1'b0, 1'b0, {8'd0, CMD_COL_SET}, 1'b0, 1'b0);
			push(1'b1, 1'b1, {7'd0, req.x}, 1'b0, 1'b0);
			push(1'b1, 1'b1, x_end, 1'b0, 1'b0);
			push(1'b0, 1'b0, {8'd0, CMD_PAGE_SET}, 1'b0, 1'b0);
			push(1'b1, 1'b1, {7'd0, req.y}, 1'b0, 1'b0);
			push(1'b1, 1'b1, y_end, 1'b0, 1'b0);
			push(1'b0, 1'b0, {8'd0, CMD_MEM_WRITE}, 1'b1, 1'b0);
			return 7;
		end
		n = (pixels_left > BITS_PER_WORD_DEF) ? BITS_PER_WORD_DEF : pixels_left;
		for (int j = 0; j < n; j++) begin
			last = (j + 1 == n);
			push(1'b1, 1'b1, req.bits[BITS_PER_WORD_DEF - 1 - j] ? fg_color : bg_color,
				last, last && (n == pixels_left));
		end
		pixels_left = pixels_left - n;
		return n;
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task check_result(result_t got);
		result_t want;
		if (stream_q.size() == 0) begin
			report($sformatf("result with nothing pending, value %h", got.value));
			return;
		end
		want = stream_q.pop_front();
		if (got.is_data !== want.is_data)
			report($sformatf("is_data %b, want %b", got.is_data, want.is_data));
		if (got.is_word !== want.is_word)
			report($sformatf("is_word %b, want %b", got.is_word, want.is_word));
		if (got.value !== want.value)
			report($sformatf("value %h, want %h", got.value, want.value));
		if (got.last !== want.last)
			report($sformatf("last %b, want %b (value %h)", got.last, want.last, want.value));
		if (got.window_done !== want.window_done)
			report($sformatf("window_done %b, want %b (value %h)", got.window_done,
				want.window_done, want.value));
	endtask
endclass

module window_bitmap_pixel_expander_tb;
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_FG_COLOR;
	logic [WORD_W-1:0]        cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     cmd = OP_WINDOW;
	logic [COORD_W-1:0]       win_x = '0;
	logic [COORD_W-1:0]       win_y = '0;
	logic [COORD_W-1:0]       win_width = '0;
	logic [COORD_W-1:0]       win_height = '0;
	logic [31:0]              bits = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     is_data;
	logic                     is_word;
	logic [WORD_W-1:0]        value;
	logic                     last;
	logic                     window_done;

	expander_scoreboard sb = new();
	result_t seen;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_timer = 0;
	int productive = 0;
	int n_results;
	int target;

	window_bitmap_pixel_expander uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.win_x(win_x),
		.win_y(win_y),
		.win_width(win_width),
		.win_height(win_height),
		.bits(bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_data(is_data),
		.is_word(is_word),
		.value(value),
		.last(last),
		.window_done(window_done)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Result sink: checks each accepted result and stalls in changing modes.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = {is_data, is_word, value, last, window_done};
			sb.check_result(seen);
		end
		if (stall_timer == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_timer = $urandom_range(16, 96);
		end else begin
			stall_timer--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_timer % 7) < 3);
		endcase
	end

	function automatic draw_req_t window_req(int x, int y, int w, int h);
		draw_req_t req;
		req.kind = OP_WINDOW;
		req.x = COORD_W'(x);
		req.y = COORD_W'(y);
		req.w = COORD_W'(w);
		req.h = COORD_W'(h);
		req.bits = $urandom();
		return req;
	endfunction

	function automatic draw_req_t word_req(logic [31:0] pattern);
		draw_req_t req;
		req.kind = OP_PIXELS;
		req.x = COORD_W'($urandom_range(0, 511));
		req.y = COORD_W'($urandom_range(0, 511));
		req.w = COORD_W'($urandom_range(0, 511));
		req.h = COORD_W'($urandom_range(0, 511));
		req.bits = pattern;
		return req;
	endfunction

	// Presents one item, waits for it to be taken, then maybe idles.
	task automatic send_request(input draw_req_t req);
		cmd <= req.kind;
		win_x <= req.x;
		win_y <= req.y;
		win_width <= req.w;
		win_height <= req.h;
		bits <= req.bits;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_results = sb.note_request(req);
		if (n_results > 0)
			productive++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Waits for every pending result, then lets trailing words with no
	// pixels left pass through the pipeline before the block counts as idle.
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (sb.stream_q.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.stream_q.size() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.stream_q.size()));
			sb.stream_q.delete();
		end
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [31:0] random_pattern();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// One drawing sequence: a window and the words that fill it, sometimes cut
	// short or padded with words past the end, sometimes a stray word alone.
	task automatic run_sequence();
		int pick;
		int w;
		int h;
		int tmp;
		int words;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			send_request(word_req(random_pattern()));
			return;
		end
		case (pick)
			1: begin
				w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 511);
				h = (w == 0) ? $urandom_range(0, 511) : 0;
			end
			2, 3, 4: begin
				w = $urandom_range(0, 511);
				h = $urandom_range(1, 2);
				if ($urandom_range(0, 1)) begin
					tmp = w;
					w = h;
					h = tmp;
				end
			end
			default: begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 12);
			end
		endcase
		send_request(window_req($urandom_range(0, 511), $urandom_range(0, 511), w, h));
		words = (sb.pixels_left + 31) / 32;
		case ($urandom_range(0, 9))
			0: words = $urandom_range(0, words);
			1: words = words + $urandom_range(1, 2);
			default: ;
		endcase
		repeat (words)
			send_request(word_req(random_pattern()));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset colors.
		send_request(word_req(32'hffff_ffff));
		send_request(window_req(0, 0, 1, 1));
		send_request(word_req(32'h7fff_ffff));
		send_request(word_req(32'hffff_ffff));
		send_request(window_req(5, 7, 0, 4));
		send_request(word_req(32'hffff_ffff));
		send_request(window_req(0, 0, 0, 0));
		send_request(window_req(511, 511, 511, 511));
		send_request(word_req(32'ha5a5_a5a5));
		send_request(word_req(32'h5a5a_5a5a));
		send_request(window_req(319, 319, 320, 320));
		send_request(word_req(32'hffff_ffff));
		send_request(word_req(32'h0000_0000));
		// A short final word: only its three leading bits are used.
		send_request(window_req(300, 200, 5, 7));
		send_request(word_req(32'hffff_ffff));
		send_request(word_req(32'hbfff_ffff));
		send_request(window_req(0, 319, 32, 1));
		send_request(word_req(32'h1234_5678));
		send_request(window_req(1, 2, 33, 1));
		send_request(word_req(32'hc3c3_c3c3));
		send_request(word_req(32'h8000_0000));
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_FG_COLOR, 16'h0000);
					write_reg(REG_BG_COLOR, 16'hffff);
				end
				1: begin
					write_reg(REG_FG_COLOR, 16'hffff);
					write_reg(REG_BG_COLOR, 16'hffff);
				end
				default: begin
					write_reg(REG_FG_COLOR, WORD_W'($urandom_range(0, 65535)));
					write_reg(REG_BG_COLOR, WORD_W'($urandom_range(0, 65535)));
				end
			endcase
			target = productive + 40;
			while (productive < target)
				run_sequence();
			settle();
		end

		if (sb.errors == 0)
			$display("window_bitmap_pixel_expander_tb: clean");
		else
			$display("window_bitmap_pixel_expander_tb: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("ERROR: run did not complete in time");
		$display("window_bitmap_pixel_expander_tb: errors");
		$finish;
	end
endmodule
